// File: hdl/csem_pkg.sv
// ----------------------------------------------------------------------------
// csem_pkg
// Shared constants, types and helpers for the counting semaphore table.
// ----------------------------------------------------------------------------
package csem_pkg;

    // Table geometry
    localparam int NUM_SEM     = 32;
    localparam int QUEUE_DEPTH = 8;
    localparam int PID_WIDTH   = 8;

    // Fixed field widths of the request and result ports
    localparam int MODE_W  = 2;
    localparam int INDEX_W = 6;
    localparam int PID_W   = 8;
    localparam int COUNT_W = 16;
    localparam int STAT_W  = 2;

    // Derived widths
    localparam int IDX_W  = (NUM_SEM > 1) ? $clog2(NUM_SEM) : 1;
    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam int WS_DEPTH = NUM_SEM * QUEUE_DEPTH;
    localparam int WS_AW  = (WS_DEPTH > 1) ? $clog2(WS_DEPTH) : 1;

    localparam logic [PID_W-1:0]   PID_MASK  =
        (PID_WIDTH >= PID_W) ? {PID_W{1'b1}} : PID_W'((1 << PID_WIDTH) - 1);
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Operation codes
    localparam logic [MODE_W-1:0] MODE_INIT   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WAIT   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SIGNAL = 2'd2;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD  = 2'd1;
    localparam logic [STAT_W-1:0] ST_BUSY = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd3;

    // One semaphore table entry
    typedef struct packed {
        logic [PID_W-1:0]   owner;
        logic [COUNT_W-1:0] count;
        logic [QPTR_W-1:0]  head;
        logic [QPTR_W-1:0]  tail;
        logic [FILL_W-1:0]  fill;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Controller to datapath commands
    typedef struct packed {
        logic load;    // capture request, launch entry read
        logic exec;    // decide, update entry and queue store
    } ctrl_cmd_t;

    function automatic logic [QPTR_W-1:0] next_slot(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [WS_AW-1:0] slot_addr(input logic [IDX_W-1:0]  idx,
                                                   input logic [QPTR_W-1:0] ptr);
        return WS_AW'(int'(idx) * QUEUE_DEPTH + int'(ptr));
    endfunction

endpackage

// File: hdl/counting_semaphore_table.sv
// ----------------------------------------------------------------------------
// counting_semaphore_table
// Table of counting semaphores with per-semaphore FIFO of blocked pids.
// A taken request passes through the execute state, then done pulses in
//   the respond state. A new request may be taken in respond but not in
//   execute, since the entry RAM's registered read is followed by its write-back.
// busy is high only in the execute cycle; done is a one-cycle strobe and
//   the receiver cannot stall it.
// Reset clears all valid flags at once (no clearing pass); queue slots are
//   only read after being written, so the queue store is not cleared.
// ----------------------------------------------------------------------------
module counting_semaphore_table (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [csem_pkg::MODE_W-1:0]   mode,
    input  logic [csem_pkg::INDEX_W-1:0]  sem_index,
    input  logic [csem_pkg::PID_W-1:0]    caller_pid,
    input  logic [csem_pkg::COUNT_W-1:0]  init_value,
    output logic                          done,
    output logic [csem_pkg::STAT_W-1:0]   status,
    output logic                          must_block,
    output logic                          woken_valid,
    output logic [csem_pkg::PID_W-1:0]    woken_pid
);

    // Command bundle from the sequencer to the datapath
    csem_pkg::ctrl_cmd_t cmd;

    // Sequencer: request n is taken in idle or respond, passes through
    // execute (entry data arrives from the RAM, entry and queue get written),
    // then its result is strobed while request n+1 may already be taken.
    csem_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    // Datapath: holds the table, the valid flags and the queue store.
    // Wake pid comes straight from the queue RAM's read register, which
    // only reloads in the execute cycle, so it is stable during done.
    csem_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .mode        (mode),
        .sem_index   (sem_index),
        .caller_pid  (caller_pid),
        .init_value  (init_value),
        .status      (status),
        .must_block  (must_block),
        .woken_valid (woken_valid),
        .woken_pid   (woken_pid)
    );

    // A taken request yields its result strobe after the execute state
    a_req_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("request did not produce a result strobe in time");

    // Results and execution never overlap
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobed while executing");

    // Blocking and waking are exclusive and only come with ok status
    a_block_wake_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (must_block || woken_valid)) |->
            (!(must_block && woken_valid) && status == csem_pkg::ST_OK))
        else $error("block/wake flags inconsistent with status");

    // No wake, no pid
    a_pid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !woken_valid) |-> (woken_pid == '0))
        else $error("woken pid nonzero without a wake");

endmodule

// File: hdl/csem_ram.sv
// ----------------------------------------------------------------------------
// csem_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module csem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/csem_ctrl.sv
// ----------------------------------------------------------------------------
// csem_ctrl
// Request sequencer: idle, execute, respond. A new request may enter while
// the previous result is being presented.
// ----------------------------------------------------------------------------
module csem_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    output logic                 done,
    output csem_pkg::ctrl_cmd_t  cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_RESP = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       accept;

    assign busy   = (state_reg == S_EXEC);
    assign done   = (state_reg == S_RESP);
    assign accept = start && !busy;

    assign cmd.load = accept;
    assign cmd.exec = (state_reg == S_EXEC);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  state_next = accept ? S_EXEC : S_IDLE;
            S_EXEC:  state_next = S_RESP;
            S_RESP:  state_next = accept ? S_EXEC : S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: hdl/csem_dp.sv
// ----------------------------------------------------------------------------
// csem_dp
// Datapath: request registers, valid flags, entry table, wait queue store
// and result registers.
// ----------------------------------------------------------------------------
module csem_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  csem_pkg::ctrl_cmd_t                  cmd,
    input  logic [csem_pkg::MODE_W-1:0]          mode,
    input  logic [csem_pkg::INDEX_W-1:0]         sem_index,
    input  logic [csem_pkg::PID_W-1:0]           caller_pid,
    input  logic [csem_pkg::COUNT_W-1:0]         init_value,
    output logic [csem_pkg::STAT_W-1:0]          status,
    output logic                                 must_block,
    output logic                                 woken_valid,
    output logic [csem_pkg::PID_W-1:0]           woken_pid
);

    // Captured request
    logic [csem_pkg::MODE_W-1:0]  mode_reg;
    logic [csem_pkg::INDEX_W-1:0] index_reg;
    logic [csem_pkg::PID_W-1:0]   pid_reg;
    logic [csem_pkg::COUNT_W-1:0] value_reg;

    logic [csem_pkg::NUM_SEM-1:0] valid_reg;
    logic [csem_pkg::NUM_SEM-1:0] valid_next;

    logic [csem_pkg::STAT_W-1:0]  status_reg;
    logic [csem_pkg::STAT_W-1:0]  status_next;
    logic                         block_reg;
    logic                         block_next;
    logic                         wake_reg;
    logic                         wake_next;

    logic [csem_pkg::IDX_W-1:0]   idx;
    logic                         in_range;
    logic                         sem_ok;
    csem_pkg::entry_t             entry_rd;
    csem_pkg::entry_t             entry_wr;
    logic [csem_pkg::ENTRY_W-1:0] entry_rdata;
    logic                         entry_we;
    logic                         ws_we;
    logic                         ws_re;
    logic [csem_pkg::WS_AW-1:0]   ws_waddr;
    logic [csem_pkg::WS_AW-1:0]   ws_raddr;
    logic [csem_pkg::PID_W-1:0]   ws_rdata;

    assign idx      = index_reg[csem_pkg::IDX_W-1:0];
    assign in_range = (int'(index_reg) < csem_pkg::NUM_SEM);
    assign sem_ok   = in_range && valid_reg[idx];
    assign entry_rd = csem_pkg::entry_t'(entry_rdata);

    assign ws_waddr = csem_pkg::slot_addr(idx, entry_rd.tail);
    assign ws_raddr = csem_pkg::slot_addr(idx, entry_rd.head);

    // Decision for the request held in the capture registers
    always_comb
    begin
        status_next = csem_pkg::ST_OK;
        block_next  = 1'b0;
        wake_next   = 1'b0;
        entry_wr    = entry_rd;
        entry_we    = 1'b0;
        ws_we       = 1'b0;
        ws_re       = 1'b0;
        valid_next  = valid_reg;

        if (!in_range)
        begin
            status_next = csem_pkg::ST_BAD;
        end
        else
        begin
            unique case (mode_reg)
                csem_pkg::MODE_INIT:
                begin
                    if (valid_reg[idx])
                    begin
                        status_next = csem_pkg::ST_BUSY;
                    end
                    else
                    begin
                        valid_next[idx] = 1'b1;
                        entry_wr.owner  = pid_reg;
                        entry_wr.count  = value_reg;
                        entry_wr.head   = '0;
                        entry_wr.tail   = '0;
                        entry_wr.fill   = '0;
                        entry_we        = 1'b1;
                    end
                end
                csem_pkg::MODE_WAIT:
                begin
                    if (!sem_ok)
                    begin
                        status_next = csem_pkg::ST_BAD;
                    end
                    else if (entry_rd.count != '0)
                    begin
                        entry_wr.count = entry_rd.count - 1'b1;
                        entry_we       = 1'b1;
                    end
                    else if (entry_rd.fill == csem_pkg::FILL_W'(csem_pkg::QUEUE_DEPTH))
                    begin
                        status_next = csem_pkg::ST_FULL;
                    end
                    else
                    begin
                        entry_wr.tail = csem_pkg::next_slot(entry_rd.tail);
                        entry_wr.fill = entry_rd.fill + 1'b1;
                        entry_we      = 1'b1;
                        ws_we         = 1'b1;
                        block_next    = 1'b1;
                    end
                end
                csem_pkg::MODE_SIGNAL:
                begin
                    if (!sem_ok)
                    begin
                        status_next = csem_pkg::ST_BAD;
                    end
                    else if (entry_rd.fill == '0)
                    begin
                        if (entry_rd.count != csem_pkg::COUNT_MAX)
                        begin
                            entry_wr.count = entry_rd.count + 1'b1;
                            entry_we       = 1'b1;
                        end
                    end
                    else
                    begin
                        entry_wr.head = csem_pkg::next_slot(entry_rd.head);
                        entry_wr.fill = entry_rd.fill - 1'b1;
                        entry_we      = 1'b1;
                        ws_re         = 1'b1;
                        wake_next     = 1'b1;
                    end
                end
                default:
                begin
                    status_next = csem_pkg::ST_BAD;
                end
            endcase
        end
    end

    // Entry table: owner, counter and queue pointers per semaphore
    csem_ram #(
        .WIDTH (csem_pkg::ENTRY_W),
        .DEPTH (csem_pkg::NUM_SEM)
    ) u_entry_ram (
        .clk   (clk),
        .we    (cmd.exec && entry_we),
        .waddr (idx),
        .wdata (entry_wr),
        .re    (cmd.load),
        .raddr (sem_index[csem_pkg::IDX_W-1:0]),
        .rdata (entry_rdata)
    );

    // Wait queue store, one ring of slots per semaphore
    csem_ram #(
        .WIDTH (csem_pkg::PID_W),
        .DEPTH (csem_pkg::WS_DEPTH)
    ) u_wait_ram (
        .clk   (clk),
        .we    (cmd.exec && ws_we),
        .waddr (ws_waddr),
        .wdata (pid_reg),
        .re    (cmd.exec && ws_re),
        .raddr (ws_raddr),
        .rdata (ws_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg  <= mode;
            index_reg <= sem_index;
            pid_reg   <= caller_pid & csem_pkg::PID_MASK;
            value_reg <= init_value;
        end
        if (cmd.exec)
        begin
            status_reg <= status_next;
            block_reg  <= block_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            wake_reg  <= 1'b0;
        end
        else if (cmd.exec)
        begin
            valid_reg <= valid_next;
            wake_reg  <= wake_next;
        end
    end

    assign status      = status_reg;
    assign must_block  = block_reg;
    assign woken_valid = wake_reg;
    assign woken_pid   = wake_reg ? ws_rdata : '0;

endmodule

// File: tb/counting_semaphore_table_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// counting_semaphore_table_tb
// Self-checking bench for the semaphore table: drives init/wait/signal
// requests through the start/busy handshake and checks every done strobe
// against a cycle-free mirror of the table and its blocked-pid FIFOs.
// ----------------------------------------------------------------------------
module counting_semaphore_table_tb;
    import csem_pkg::*;

    // Mode 3 is not an operation; the block must reject it
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int IDLE_LIMIT   = 1000;   // cycles with no request or result taken
    localparam int DRAIN_CYCLES = 4;      // done comes in the respond state after acceptance
    localparam int HOT_SEMS     = 4;      // semaphores that get most of the traffic

    // Expected result of one request
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              must_block;
        logic              woken_valid;
        logic [PID_W-1:0]  woken_pid;
    } sem_result_t;

    // Clock, reset and request side; all known from time zero
    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 start      = 1'b0;
    logic [MODE_W-1:0]    mode       = MODE_INIT;
    logic [INDEX_W-1:0]   sem_index  = '0;
    logic [PID_W-1:0]     caller_pid = '0;
    logic [COUNT_W-1:0]   init_value = '0;

    // Result side
    logic                 busy;
    logic                 done;
    logic [STAT_W-1:0]    status;
    logic                 must_block;
    logic                 woken_valid;
    logic [PID_W-1:0]     woken_pid;

    counting_semaphore_table uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .mode        (mode),
        .sem_index   (sem_index),
        .caller_pid  (caller_pid),
        .init_value  (init_value),
        .done        (done),
        .status      (status),
        .must_block  (must_block),
        .woken_valid (woken_valid),
        .woken_pid   (woken_pid)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Mirror of the semaphore table
    // ------------------------------------------------------------------
    logic               sem_live    [NUM_SEM];
    logic [COUNT_W-1:0] sem_level   [NUM_SEM];
    logic [PID_W-1:0]   blocked_pid [NUM_SEM][QUEUE_DEPTH];
    int                 q_head      [NUM_SEM];
    int                 q_tail      [NUM_SEM];
    int                 q_fill      [NUM_SEM];

    // Results still owed by the block, oldest first
    sem_result_t pending_results [$];

    int error_count   = 0;
    int request_count = 0;
    int block_count   = 0;
    int wake_count    = 0;
    int sat_count     = 0;
    int status_tally [4] = '{0, 0, 0, 0};

    // Applies one request to the mirror and returns what the block must say
    function automatic sem_result_t apply_request(input logic [MODE_W-1:0]  m,
                                                  input logic [INDEX_W-1:0] idx,
                                                  input logic [PID_W-1:0]   pid,
                                                  input logic [COUNT_W-1:0] val);
        sem_result_t r;
        int s;
        r = '0;
        s = int'(idx);
        if (s >= NUM_SEM || m == MODE_UNUSED)
        begin
            r.status = ST_BAD;
        end
        else if (m == MODE_INIT)
        begin
            // Init only once; there is no destroy
            if (sem_live[s])
                r.status = ST_BUSY;
            else
            begin
                sem_live[s]  = 1'b1;
                sem_level[s] = val;
            end
        end
        else if (!sem_live[s])
        begin
            r.status = ST_BAD;
        end
        else if (m == MODE_WAIT)
        begin
            if (sem_level[s] != '0)
                sem_level[s] = sem_level[s] - 1'b1;
            else if (q_fill[s] >= QUEUE_DEPTH)
                r.status = ST_FULL;
            else
            begin
                blocked_pid[s][q_tail[s]] = pid & PID_MASK;
                q_tail[s] = (q_tail[s] + 1) % QUEUE_DEPTH;
                q_fill[s]++;
                r.must_block = 1'b1;
            end
        end
        else
        begin
            // Signal: wake the oldest sleeper first, else bump the counter
            if (q_fill[s] == 0)
            begin
                if (sem_level[s] != COUNT_MAX)
                    sem_level[s] = sem_level[s] + 1'b1;
                else
                    sat_count++;
            end
            else
            begin
                r.woken_valid = 1'b1;
                r.woken_pid   = blocked_pid[s][q_head[s]];
                q_head[s] = (q_head[s] + 1) % QUEUE_DEPTH;
                q_fill[s]--;
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request driver. Called at a rising edge; leaves start high on return
    // so the next request can follow back to back.
    // ------------------------------------------------------------------
    task automatic send_request(input logic [MODE_W-1:0]  m,
                                input logic [INDEX_W-1:0] idx,
                                input logic [PID_W-1:0]   pid,
                                input logic [COUNT_W-1:0] val);
        sem_result_t r;
        start      <= 1'b1;
        mode       <= m;
        sem_index  <= idx;
        caller_pid <= pid;
        init_value <= val;
        // Taken at the first edge that sees busy low
        do
            @(posedge clk);
        while (busy);
        r = apply_request(m, idx, pid, val);
        pending_results.push_back(r);
        request_count++;
        status_tally[r.status]++;
        if (r.must_block)
            block_count++;
        if (r.woken_valid)
            wake_count++;
    endtask

    // Sender gap: start low for a number of cycles
    task automatic pause(input int cycles);
        if (cycles > 0)
        begin
            start <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // ------------------------------------------------------------------
    // Result checker. done is a one-cycle strobe; sampled at the edge that
    // ends the cycle, so the values are those the block held before it.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_results
        sem_result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("done strobe with no request outstanding");
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    error_count++;
                end
                if (must_block !== want.must_block)
                begin
                    $error("must_block: expected %0d, got %0d", want.must_block, must_block);
                    error_count++;
                end
                if (woken_valid !== want.woken_valid)
                begin
                    $error("woken_valid: expected %0d, got %0d",
                           want.woken_valid, woken_valid);
                    error_count++;
                end
                if (woken_pid !== want.woken_pid)
                begin
                    $error("woken_pid: expected %0d, got %0d", want.woken_pid, woken_pid);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: a hung handshake or a lost result stops the run
    int idle_cycles = 0;
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Out-of-range index, uninitialized semaphore, unused mode
    task automatic test_bad_requests();
        send_request(MODE_INIT,   6'd63,             8'hFF, 16'hFFFF);
        send_request(MODE_INIT,   INDEX_W'(NUM_SEM), 8'h00, 16'h0000);
        send_request(MODE_WAIT,   6'd0,              8'h5A, 16'h0000);
        send_request(MODE_SIGNAL, 6'd31,             8'hA5, 16'h0000);
        send_request(MODE_UNUSED, 6'd5,              8'h11, 16'h1234);
        send_request(MODE_WAIT,   6'd63,             8'h22, 16'h0000);
    endtask

    // Init at the top of the counter, repeated init, signal saturation
    task automatic test_init_and_saturation();
        send_request(MODE_INIT,   6'd0, 8'hFF, 16'hFFFF);
        send_request(MODE_INIT,   6'd0, 8'h00, 16'h0000);
        send_request(MODE_SIGNAL, 6'd0, 8'h01, 16'h0000);
        send_request(MODE_WAIT,   6'd0, 8'h02, 16'h0000);
        send_request(MODE_SIGNAL, 6'd0, 8'h03, 16'h0000);
        send_request(MODE_SIGNAL, 6'd0, 8'h04, 16'h0000);
    endtask

    // Fill a wait queue, overflow it, wake the oldest waiter, wrap the tail pointer
    task automatic test_wait_queue();
        int i;
        send_request(MODE_INIT, 6'd31, 8'h00, 16'h0000);
        for (i = 0; i < QUEUE_DEPTH; i++)
            send_request(MODE_WAIT, 6'd31, {4'(i), 4'(~i)}, 16'hFFFF);
        send_request(MODE_WAIT,   6'd31, 8'hEE, 16'h0000);  // queue full
        send_request(MODE_SIGNAL, 6'd31, 8'h00, 16'h0000);  // wakes the first
        send_request(MODE_WAIT,   6'd31, 8'hC3, 16'h0000);  // tail wraps
        send_request(MODE_UNUSED, 6'd31, 8'h3C, 16'h0000);
    endtask

    // Random traffic in bursts. Most requests go to a few hot semaphores
    // with small counters so queues fill and drain; the wait/signal mix
    // drifts every hundred requests.
    task automatic test_random(input int count);
        int i;
        int burst;
        int wait_pct;
        int roll;
        logic [MODE_W-1:0]  m;
        logic [INDEX_W-1:0] idx;
        logic [COUNT_W-1:0] val;
        burst    = 0;
        wait_pct = 50;
        for (i = 0; i < count; i++)
        begin
            if (i % 100 == 0)
                wait_pct = $urandom_range(25, 75);
            if (burst == 0)
            begin
                pause(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
                burst = $urandom_range(1, 40);
            end
            burst--;

            roll = $urandom_range(0, 99);
            if (roll < 6)
                m = MODE_INIT;
            else if (roll < 8)
                m = MODE_UNUSED;
            else if ($urandom_range(0, 99) < wait_pct)
                m = MODE_WAIT;
            else
                m = MODE_SIGNAL;

            roll = $urandom_range(0, 99);
            if (roll < 70)
                idx = INDEX_W'($urandom_range(0, HOT_SEMS - 1));
            else if (roll < 92)
                idx = INDEX_W'($urandom_range(0, NUM_SEM - 1));
            else
                idx = INDEX_W'($urandom_range(0, 63));

            // Hot semaphores start near zero; others see the full range
            roll = $urandom_range(0, 3);
            if (idx < HOT_SEMS || roll < 2)
                val = COUNT_W'($urandom_range(0, 2));
            else if (roll == 2)
                val = COUNT_W'($urandom_range(0, 65535));
            else
                val = COUNT_W'($urandom_range(16'hFFF0, 16'hFFFF));

            send_request(m, idx, PID_W'($urandom_range(0, 255)), val);
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        for (int s = 0; s < NUM_SEM; s++)
        begin
            sem_live[s]  = 1'b0;
            sem_level[s] = '0;
            q_head[s]    = 0;
            q_tail[s]    = 0;
            q_fill[s]    = 0;
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_bad_requests();
        test_init_and_saturation();
        test_wait_queue();
        test_random(1600);
        start <= 1'b0;

        // Every owed result must show up; the watchdog bounds this
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d requests: %0d ok, %0d rejected, %0d repeated init, %0d queue full",
                 request_count, status_tally[ST_OK], status_tally[ST_BAD],
                 status_tally[ST_BUSY], status_tally[ST_FULL]);
        $display("%0d callers blocked, %0d woken, %0d signals at counter max",
                 block_count, wake_count, sat_count);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
